// ----- rtl/core/knnv_pkg.sv -----
// ----------------------------------------------------------------------------
// knnv_pkg
// Widths and controller/datapath interface types for the top-k label vote.
// ----------------------------------------------------------------------------
package knnv_pkg;

    localparam int COORD_W    = 16;
    localparam int MAG_W      = COORD_W + 1;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int DIST_W     = 40;
    localparam int IDX_W      = 20;
    localparam int LBL_W      = 4;
    localparam int CFG_W      = 5;
    localparam int SLOT_OUT_W = 4;
    localparam int NUM_CODES  = 1 << LBL_W;

    typedef struct packed {
        logic take;
        logic square;
        logic accum;
        logic insert;
        logic vote_start;
        logic count_step;
        logic best_step;
        logic emit;
        logic list_clr;
    } t_cmd;

    typedef struct packed {
        logic last_dim;
        logic last_cand;
        logic slot_last;
        logic lbl_last;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/core/knnv_ctrl.sv -----
// ----------------------------------------------------------------------------
// knnv_ctrl
// Sequencer: input transfer, square, accumulate, insert, vote, emission.
// ----------------------------------------------------------------------------
module knnv_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  knnv_pkg::t_sts  i_sts,
    output knnv_pkg::t_cmd  o_cmd
);
    import knnv_pkg::*;

    localparam logic [2:0] S_IN   = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_INS  = 3'd3;
    localparam logic [2:0] S_CNT  = 3'd4;
    localparam logic [2:0] S_BEST = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_stall = (r_state != S_IN);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IN: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.square = 1'b1;
                n_state      = S_ACC;
            end
            S_ACC: begin
                o_cmd.accum = 1'b1;
                n_state     = i_sts.last_dim ? S_INS : S_IN;
            end
            S_INS: begin
                o_cmd.insert = 1'b1;
                if (i_sts.last_cand) begin
                    o_cmd.vote_start = 1'b1;
                    n_state          = S_CNT;
                end else begin
                    n_state = S_IN;
                end
            end
            S_CNT: begin
                o_cmd.count_step = 1'b1;
                if (i_sts.slot_last) n_state = S_BEST;
            end
            S_BEST: begin
                o_cmd.best_step = 1'b1;
                if (i_sts.lbl_last) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.slot_last) begin
                        o_cmd.list_clr = 1'b1;
                        n_state        = S_IN;
                    end
                end
            end
            default: begin
                n_state = S_IN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/core/knnv_dpath.sv -----
// ----------------------------------------------------------------------------
// knnv_dpath
// Distance accumulator, sorted neighbour list, label counters, output register.
// ----------------------------------------------------------------------------
module knnv_dpath #(
    parameter int K_MAX      = 16,
    parameter int NUM_LABELS = 10,
    parameter int KW         = $clog2(K_MAX + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  knnv_pkg::t_cmd                      i_cmd,
    output knnv_pkg::t_sts                      o_sts,
    input  logic [KW-1:0]                       i_k_eff,
    input  logic signed [knnv_pkg::COORD_W-1:0] i_query_coord,
    input  logic signed [knnv_pkg::COORD_W-1:0] i_cand_coord,
    input  logic [knnv_pkg::IDX_W-1:0]          i_cand_index,
    input  logic [knnv_pkg::LBL_W-1:0]          i_cand_label,
    input  logic [knnv_pkg::IDX_W-1:0]          i_query_index,
    input  logic [knnv_pkg::LBL_W-1:0]          i_query_label,
    input  logic                                i_last_dim,
    input  logic                                i_last_cand,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [knnv_pkg::SLOT_OUT_W-1:0]     o_slot,
    output logic                                o_slot_valid,
    output logic [knnv_pkg::DIST_W-1:0]         o_distance,
    output logic [knnv_pkg::IDX_W-1:0]          o_neighbour_index,
    output logic [knnv_pkg::LBL_W-1:0]          o_neighbour_label,
    output logic [knnv_pkg::LBL_W-1:0]          o_predicted_label,
    output logic                                o_label_match,
    output logic                                o_last
);
    import knnv_pkg::*;

    localparam int SW    = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int CNT_W = $clog2(K_MAX + 1);

    logic signed [COORD_W-1:0] r_qc;
    logic signed [COORD_W-1:0] r_cc;
    logic [IDX_W-1:0]          r_cidx;
    logic [LBL_W-1:0]          r_clbl;
    logic [IDX_W-1:0]          r_qidx;
    logic [LBL_W-1:0]          r_qlbl;
    logic                      r_ld;
    logic                      r_lc;
    logic [SQ_W-1:0]           r_sq;
    logic [DIST_W-1:0]         r_acc;
    logic [DIST_W-1:0]         r_sum;

    logic [DIST_W-1:0]         r_dist [K_MAX];
    logic [IDX_W-1:0]          r_idx  [K_MAX];
    logic [LBL_W-1:0]          r_lab  [K_MAX];
    logic [K_MAX-1:0]          r_valid;

    logic [CNT_W-1:0]          r_cnt  [NUM_CODES];
    logic [CNT_W-1:0]          r_best;
    logic [LBL_W-1:0]          r_pred;
    logic [LBL_W-1:0]          r_lbl;
    logic [SW-1:0]             r_slot;

    logic                      r_ov;
    logic [SLOT_OUT_W-1:0]     r_o_slot;
    logic                      r_o_sv;
    logic [DIST_W-1:0]         r_o_dist;
    logic [IDX_W-1:0]          r_o_idx;
    logic [LBL_W-1:0]          r_o_lab;
    logic [LBL_W-1:0]          r_o_pred;
    logic                      r_o_match;
    logic                      r_o_last;

    logic signed [MAG_W-1:0]   diff;
    logic [MAG_W-1:0]          mag;
    logic [DIST_W:0]           sum_wide;
    logic [DIST_W-1:0]         sum_sat;
    logic [K_MAX-1:0]          in_k;
    logic [K_MAX-1:0]          hit;
    logic [K_MAX-1:0]          prev_hit;
    logic                      do_ins;
    logic [KW-1:0]             k_m1;
    logic                      slot_last;
    logic [SW+SLOT_OUT_W-1:0]  slot_ext;
    logic [LBL_W-1:0]          cur_lab;
    logic                      cur_valid;

    assign diff     = MAG_W'(r_qc) - MAG_W'(r_cc);
    assign mag      = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    assign sum_wide = {1'b0, r_acc} + (DIST_W + 1)'(r_sq);
    assign sum_sat  = sum_wide[DIST_W] ? '1 : sum_wide[DIST_W-1:0];

    assign k_m1      = i_k_eff - KW'(1);
    assign slot_last = (KW'(r_slot) == k_m1);
    assign slot_ext  = {{SLOT_OUT_W{1'b0}}, r_slot};
    assign cur_lab   = r_lab[r_slot];
    assign cur_valid = r_valid[r_slot];
    assign do_ins    = i_cmd.insert && (r_cidx != r_qidx);

    always_comb begin
        for (int i = 0; i < K_MAX; i++) begin
            in_k[i] = (KW'(i) < i_k_eff);
            hit[i]  = in_k[i] && (!r_valid[i] || (r_sum < r_dist[i]));
        end
        prev_hit[0] = 1'b0;
        for (int i = 1; i < K_MAX; i++) begin
            prev_hit[i] = hit[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_qc   <= i_query_coord;
            r_cc   <= i_cand_coord;
            r_cidx <= i_cand_index;
            r_clbl <= i_cand_label;
            r_qidx <= i_query_index;
            r_qlbl <= i_query_label;
            r_ld   <= i_last_dim;
            r_lc   <= i_last_cand;
        end
        if (i_cmd.square) begin
            r_sq <= SQ_W'(mag) * SQ_W'(mag);
        end
        if (i_cmd.accum) begin
            r_sum <= sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.accum) begin
            r_acc <= r_ld ? '0 : sum_sat;
        end
    end

    // shift the tail down one slot and drop the new candidate into the gap
    always_ff @(posedge i_clk) begin
        if (do_ins) begin
            for (int i = 0; i < K_MAX; i++) begin
                if (hit[i] && !prev_hit[i]) begin
                    r_dist[i] <= r_sum;
                    r_idx[i]  <= r_cidx;
                    r_lab[i]  <= r_clbl;
                end
            end
            for (int i = 1; i < K_MAX; i++) begin
                if (prev_hit[i] && in_k[i]) begin
                    r_dist[i] <= r_dist[i-1];
                    r_idx[i]  <= r_idx[i-1];
                    r_lab[i]  <= r_lab[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.list_clr) begin
            r_valid <= '0;
        end else if (do_ins) begin
            for (int i = 0; i < K_MAX; i++) begin
                if (hit[i] && !prev_hit[i]) begin
                    r_valid[i] <= 1'b1;
                end
            end
            for (int i = 1; i < K_MAX; i++) begin
                if (prev_hit[i] && in_k[i]) begin
                    r_valid[i] <= r_valid[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NUM_CODES; l++) begin
            if (i_cmd.vote_start) begin
                r_cnt[l] <= '0;
            end else if (i_cmd.count_step && cur_valid && (cur_lab == LBL_W'(l)) &&
                         (l >= 1) && (l <= NUM_LABELS)) begin
                r_cnt[l] <= r_cnt[l] + CNT_W'(1);
            end
        end
        if (i_cmd.vote_start) begin
            r_best <= '0;
            r_pred <= '0;
            r_lbl  <= LBL_W'(1);
        end else if (i_cmd.best_step) begin
            if (r_cnt[r_lbl] > r_best) begin
                r_best <= r_cnt[r_lbl];
                r_pred <= r_lbl;
            end
            r_lbl <= r_lbl + LBL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (i_cmd.vote_start) begin
            r_slot <= '0;
        end else if (i_cmd.count_step || i_cmd.emit) begin
            r_slot <= slot_last ? '0 : r_slot + SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_slot  <= slot_ext[SLOT_OUT_W-1:0];
            r_o_sv    <= cur_valid;
            r_o_dist  <= cur_valid ? r_dist[r_slot] : '0;
            r_o_idx   <= cur_valid ? r_idx[r_slot] : '0;
            r_o_lab   <= cur_valid ? cur_lab : '0;
            r_o_pred  <= slot_last ? r_pred : '0;
            r_o_match <= slot_last && (r_pred == r_qlbl);
            r_o_last  <= slot_last;
        end
    end

    assign o_sts.last_dim  = r_ld;
    assign o_sts.last_cand = r_lc;
    assign o_sts.slot_last = slot_last;
    assign o_sts.lbl_last  = (r_lbl == LBL_W'(NUM_LABELS));
    assign o_sts.out_free  = !r_ov || !i_out_stall;

    assign o_out_valid       = r_ov;
    assign o_slot            = r_o_slot;
    assign o_slot_valid      = r_o_sv;
    assign o_distance        = r_o_dist;
    assign o_neighbour_index = r_o_idx;
    assign o_neighbour_label = r_o_lab;
    assign o_predicted_label = r_o_pred;
    assign o_label_match     = r_o_match;
    assign o_last            = r_o_last;

    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_valid >> 1) & ~r_valid) == '0)
        else $error("list valid bits are not a prefix");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_ov || !i_out_stall))
        else $error("result loaded over a stalled transfer");

    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accum && r_ld) |=> (r_acc == '0))
        else $error("accumulator not cleared after final dimension");

endmodule

// ----- rtl/core/knn_top_k_with_label_vote.sv -----
// ----------------------------------------------------------------------------
// knn_top_k_with_label_vote
// Squared-distance k nearest neighbours with a majority label vote.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): one coordinate pair per transfer,
// tagged with candidate and query index/label and the last_dim / last_cand
// marks. Output channel (o_out_valid / i_out_stall): one result per list slot.
// i_cfg_we / i_cfg_wdata set k; write only while the block is idle.
// Items are taken one at a time through the transfer, square and accumulate
// states; one with last_dim set also takes the parallel slot insert. After an
// item with last_dim and last_cand, the vote counts the labels of the k slots
// and picks the best of labels 1 to NUM_LABELS; k results then leave one per
// cycle via the output register; the input stalls until the last is loaded.
// Reset clears the accumulator, empties the list and sets k to 4.
// A stalled receiver holds the output register and pauses emission.
// ----------------------------------------------------------------------------
module knn_top_k_with_label_vote #(
    parameter int K_MAX      = 16,
    parameter int NUM_LABELS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [knnv_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [knnv_pkg::COORD_W-1:0] i_query_coord,
    input  logic signed [knnv_pkg::COORD_W-1:0] i_cand_coord,
    input  logic [knnv_pkg::IDX_W-1:0]          i_cand_index,
    input  logic [knnv_pkg::LBL_W-1:0]          i_cand_label,
    input  logic [knnv_pkg::IDX_W-1:0]          i_query_index,
    input  logic [knnv_pkg::LBL_W-1:0]          i_query_label,
    input  logic                                i_last_dim,
    input  logic                                i_last_cand,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [knnv_pkg::SLOT_OUT_W-1:0]     o_slot,
    output logic                                o_slot_valid,
    output logic [knnv_pkg::DIST_W-1:0]         o_distance,
    output logic [knnv_pkg::IDX_W-1:0]          o_neighbour_index,
    output logic [knnv_pkg::LBL_W-1:0]          o_neighbour_label,
    output logic [knnv_pkg::LBL_W-1:0]          o_predicted_label,
    output logic                                o_label_match,
    output logic                                o_last
);
    import knnv_pkg::*;

    localparam int KW = $clog2(K_MAX + 1);

    logic [CFG_W-1:0] r_k;
    logic [KW-1:0]    k_eff;
    t_cmd             cmd;
    t_sts             sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= CFG_W'(4);
        end else if (i_cfg_we) begin
            r_k <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_k == '0) begin
            k_eff = KW'(1);
        end else if (int'(r_k) > K_MAX) begin
            k_eff = KW'(K_MAX);
        end else begin
            k_eff = KW'(r_k);
        end
    end

    knnv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    knnv_dpath #(
        .K_MAX      (K_MAX),
        .NUM_LABELS (NUM_LABELS),
        .KW         (KW)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_k_eff           (k_eff),
        .i_query_coord     (i_query_coord),
        .i_cand_coord      (i_cand_coord),
        .i_cand_index      (i_cand_index),
        .i_cand_label      (i_cand_label),
        .i_query_index     (i_query_index),
        .i_query_label     (i_query_label),
        .i_last_dim        (i_last_dim),
        .i_last_cand       (i_last_cand),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_slot            (o_slot),
        .o_slot_valid      (o_slot_valid),
        .o_distance        (o_distance),
        .o_neighbour_index (o_neighbour_index),
        .o_neighbour_label (o_neighbour_label),
        .o_predicted_label (o_predicted_label),
        .o_label_match     (o_label_match),
        .o_last            (o_last)
    );

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the k nearest neighbours label vote block.
// Coordinate pairs are streamed in, grouped as candidates and queries. An
// in-bench model ranks the candidates by squared distance and votes over
// their labels. Each emitted slot is checked field by field, in order.
// Directed tests cover the reset k, empty slots, invalid labels, ties, self
// exclusion, stray last-candidate marks and k extremes.
// Random traffic then runs under changing k and source/sink idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import knnv_pkg::*;

    localparam int K_MAX         = 16;
    localparam int NUM_LABELS    = 10;
    localparam int SETTLE_CYCLES = 2 * K_MAX + NUM_LABELS + 16;
    localparam int MAX_DIMS      = 8;
    localparam int PHASE_ITEMS   = 26;
    localparam logic [DIST_W-1:0] DIST_SAT = '1;

    typedef struct {
        logic signed [COORD_W-1:0] query_coord;
        logic signed [COORD_W-1:0] cand_coord;
        logic [IDX_W-1:0]          cand_index;
        logic [LBL_W-1:0]          cand_label;
        logic [IDX_W-1:0]          query_index;
        logic [LBL_W-1:0]          query_label;
        logic                      last_dim;
        logic                      last_cand;
    } coord_pair_t;

    typedef struct {
        logic [SLOT_OUT_W-1:0] slot;
        logic                  slot_valid;
        logic [DIST_W-1:0]     distance;
        logic [IDX_W-1:0]      neighbour_index;
        logic [LBL_W-1:0]      neighbour_label;
        logic [LBL_W-1:0]      predicted_label;
        logic                  label_match;
        logic                  last;
    } neighbour_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_W-1:0]          i_cfg_wdata = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic signed [COORD_W-1:0] i_query_coord = '0;
    logic signed [COORD_W-1:0] i_cand_coord = '0;
    logic [IDX_W-1:0]          i_cand_index = '0;
    logic [LBL_W-1:0]          i_cand_label = '0;
    logic [IDX_W-1:0]          i_query_index = '0;
    logic [LBL_W-1:0]          i_query_label = '0;
    logic                      i_last_dim = 1'b0;
    logic                      i_last_cand = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [SLOT_OUT_W-1:0]     o_slot;
    logic                      o_slot_valid;
    logic [DIST_W-1:0]         o_distance;
    logic [IDX_W-1:0]          o_neighbour_index;
    logic [LBL_W-1:0]          o_neighbour_label;
    logic [LBL_W-1:0]          o_predicted_label;
    logic                      o_label_match;
    logic                      o_last;

    knn_top_k_with_label_vote #(
        .K_MAX      (K_MAX),
        .NUM_LABELS (NUM_LABELS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_query_coord     (i_query_coord),
        .i_cand_coord      (i_cand_coord),
        .i_cand_index      (i_cand_index),
        .i_cand_label      (i_cand_label),
        .i_query_index     (i_query_index),
        .i_query_label     (i_query_label),
        .i_last_dim        (i_last_dim),
        .i_last_cand       (i_last_cand),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_slot            (o_slot),
        .o_slot_valid      (o_slot_valid),
        .o_distance        (o_distance),
        .o_neighbour_index (o_neighbour_index),
        .o_neighbour_label (o_neighbour_label),
        .o_predicted_label (o_predicted_label),
        .o_label_match     (o_label_match),
        .o_last            (o_last)
    );

    // model state
    logic [CFG_W-1:0]  k_setting;
    logic [DIST_W-1:0] dist_sum;
    logic [DIST_W-1:0] top_dist [K_MAX];
    logic [IDX_W-1:0]  top_idx [K_MAX];
    logic [LBL_W-1:0]  top_lbl [K_MAX];
    logic              top_used [K_MAX];
    neighbour_t        pending_neighbours [$];

    int feed_idle_pct = 0;
    int sink_stall_pct = 0;
    int fail_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int votes_predicted = 0;
    int k_writes = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d neighbour results outstanding", pending_neighbours.size());
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int effective_k();
        if (k_setting == 0) return 1;
        if (k_setting > K_MAX) return K_MAX;
        return int'(k_setting);
    endfunction

    task automatic rank_candidate(input logic [DIST_W-1:0] d, input logic [IDX_W-1:0] idx,
                                  input logic [LBL_W-1:0] lbl, input int k);
        int pos;
        pos = 0;
        while (pos < k && top_used[pos] && d >= top_dist[pos]) pos++;
        if (pos < k) begin
            for (int s = k - 1; s > pos; s--) begin
                top_dist[s] = top_dist[s - 1];
                top_idx[s]  = top_idx[s - 1];
                top_lbl[s]  = top_lbl[s - 1];
                top_used[s] = top_used[s - 1];
            end
            top_dist[pos] = d;
            top_idx[pos]  = idx;
            top_lbl[pos]  = lbl;
            top_used[pos] = 1'b1;
        end
    endtask

    function automatic logic [LBL_W-1:0] majority_label(input int k);
        int counts [NUM_CODES];
        int best;
        logic [LBL_W-1:0] winner;
        best = 0;
        winner = '0;
        foreach (counts[i]) counts[i] = 0;
        for (int i = 0; i < k; i++) begin
            if (top_used[i] && top_lbl[i] >= 1 && top_lbl[i] <= NUM_LABELS)
                counts[top_lbl[i]]++;
        end
        for (int l = 1; l <= NUM_LABELS; l++) begin
            if (counts[l] > best) begin
                best = counts[l];
                winner = LBL_W'(l);
            end
        end
        return winner;
    endfunction

    task automatic predict_pair(input coord_pair_t p);
        logic signed [COORD_W:0] diff;
        logic [COORD_W:0] mag;
        logic [63:0] total;
        logic [LBL_W-1:0] winner;
        neighbour_t r;
        int k;
        diff = p.query_coord - p.cand_coord;
        mag = (diff < 0) ? -diff : diff;
        total = 64'(dist_sum) + 64'(mag) * 64'(mag);
        if (total > 64'(DIST_SAT)) total = 64'(DIST_SAT);
        if (!p.last_dim) begin
            dist_sum = total[DIST_W-1:0];
            return;
        end
        dist_sum = '0;
        k = effective_k();
        if (p.cand_index != p.query_index)
            rank_candidate(total[DIST_W-1:0], p.cand_index, p.cand_label, k);
        if (!p.last_cand) return;
        winner = majority_label(k);
        for (int i = 0; i < k; i++) begin
            r.slot            = SLOT_OUT_W'(i);
            r.slot_valid      = top_used[i];
            r.distance        = top_used[i] ? top_dist[i] : '0;
            r.neighbour_index = top_used[i] ? top_idx[i] : '0;
            r.neighbour_label = top_used[i] ? top_lbl[i] : '0;
            r.predicted_label = (i == k - 1) ? winner : '0;
            r.label_match     = (i == k - 1) && (winner == p.query_label);
            r.last            = (i == k - 1);
            pending_neighbours.push_back(r);
        end
        foreach (top_used[i]) top_used[i] = 1'b0;
        votes_predicted++;
    endtask

    function automatic string fmt_neighbour(input neighbour_t n);
        return $sformatf("slot=%0d valid=%0b dist=%0d idx=%0d lbl=%0d pred=%0d match=%0b last=%0b",
                         n.slot, n.slot_valid, n.distance, n.neighbour_index,
                         n.neighbour_label, n.predicted_label, n.label_match, n.last);
    endfunction

    always @(negedge i_clk) begin
        i_out_stall = ($urandom_range(99) < sink_stall_pct);
    end

    always @(posedge i_clk) begin
        neighbour_t got;
        neighbour_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_slot, o_slot_valid, o_distance, o_neighbour_index, o_neighbour_label,
                    o_predicted_label, o_label_match, o_last};
            if (pending_neighbours.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: %s", fmt_neighbour(got));
            end else begin
                want = pending_neighbours.pop_front();
                results_checked++;
                if (got.slot !== want.slot || got.slot_valid !== want.slot_valid ||
                    got.distance !== want.distance ||
                    got.neighbour_index !== want.neighbour_index ||
                    got.neighbour_label !== want.neighbour_label ||
                    got.predicted_label !== want.predicted_label ||
                    got.label_match !== want.label_match || got.last !== want.last) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch at %0t", $realtime);
                        $display("  expected %s", fmt_neighbour(want));
                        $display("  actual   %s", fmt_neighbour(got));
                    end
                end
            end
        end
    end

    task automatic send_pair(input coord_pair_t p);
        @(negedge i_clk);
        while ($urandom_range(99) < feed_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_query_coord = p.query_coord;
        i_cand_coord  = p.cand_coord;
        i_cand_index  = p.cand_index;
        i_cand_label  = p.cand_label;
        i_query_index = p.query_index;
        i_query_label = p.query_label;
        i_last_dim    = p.last_dim;
        i_last_cand   = p.last_cand;
        i_in_valid    = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predict_pair(p);
        items_sent++;
    endtask

    // one-dimension candidate
    task automatic send_cand(input logic [IDX_W-1:0] qidx, input logic [LBL_W-1:0] qlbl,
                             input int qc, input int cc, input logic [IDX_W-1:0] cidx,
                             input logic [LBL_W-1:0] clbl, input logic final_cand);
        coord_pair_t p;
        p = '{COORD_W'(qc), COORD_W'(cc), cidx, clbl, qidx, qlbl, 1'b1, final_cand};
        send_pair(p);
    endtask

    task automatic drain_block();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_neighbours.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_k(input logic [CFG_W-1:0] v);
        drain_block();
        i_cfg_we = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        k_setting = v;
        k_writes++;
    endtask

    function automatic logic [LBL_W-1:0] pick_label();
        if ($urandom_range(7) == 0) return LBL_W'($urandom);
        return LBL_W'($urandom_range(1, 4));
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord(input int span);
        if (span == 0) return COORD_W'($urandom);
        return COORD_W'($urandom_range(0, 2 * span)) - COORD_W'(span);
    endfunction

    task automatic send_query(input int n_cand, input int n_dim, input int span,
                              input int self_pct);
        logic signed [COORD_W-1:0] qvec [MAX_DIMS];
        coord_pair_t p;
        foreach (qvec[d]) qvec[d] = pick_coord(span);
        p.query_index = IDX_W'($urandom);
        p.query_label = pick_label();
        for (int c = 0; c < n_cand; c++) begin
            p.cand_index = ($urandom_range(99) < self_pct) ? p.query_index : IDX_W'($urandom);
            p.cand_label = pick_label();
            for (int d = 0; d < n_dim; d++) begin
                p.query_coord = qvec[d];
                p.cand_coord  = pick_coord(span);
                p.last_dim    = (d == n_dim - 1);
                p.last_cand   = p.last_dim && (c == n_cand - 1);
                send_pair(p);
            end
        end
    endtask

    task automatic send_noise();
        coord_pair_t p;
        p = '{COORD_W'($urandom), COORD_W'($urandom), IDX_W'($urandom), LBL_W'($urandom),
              IDX_W'($urandom), LBL_W'($urandom), 1'($urandom), 1'($urandom)};
        send_pair(p);
    endtask

    // reset k of 4, tie order, self exclusion, more candidates than slots
    task automatic test_default_k();
        send_cand(20'd100, 4'd2, 0, 3, 20'd1, 4'd2, 1'b0);
        send_cand(20'd100, 4'd2, 0, -3, 20'd2, 4'd3, 1'b0);
        send_cand(20'd100, 4'd2, 0, 0, 20'd100, 4'd5, 1'b0);
        send_cand(20'd100, 4'd2, 0, 1, 20'd3, 4'd3, 1'b0);
        send_cand(20'd100, 4'd2, 0, 5, 20'd4, 4'd2, 1'b0);
        send_cand(20'd100, 4'd2, 0, 2, 20'd5, 4'd7, 1'b1);
    endtask

    // empty slots, coordinate and index extremes, labels with no vote
    task automatic test_invalid_labels();
        send_cand(20'hFFFFF, 4'd0, -32768, 32767, 20'd0, 4'd0, 1'b0);
        send_cand(20'hFFFFF, 4'd0, 32767, -32768, 20'hFFFFE, 4'd15, 1'b1);
    endtask

    // last_cand without last_dim, then a self match closing the query
    task automatic test_mark_and_self();
        coord_pair_t p;
        p = '{16'sd10, 16'sd0, 20'd9, 4'd4, 20'd55, 4'd2, 1'b0, 1'b1};
        send_pair(p);
        p = '{16'sd0, 16'sd2, 20'd9, 4'd4, 20'd55, 4'd2, 1'b1, 1'b0};
        send_pair(p);
        send_cand(20'd55, 4'd2, 0, 10, 20'd8, 4'd2, 1'b0);
        send_cand(20'd55, 4'd2, 0, 0, 20'd55, 4'd6, 1'b1);
    endtask

    // register extremes: 0 acts as 1, 16 and above as 16
    task automatic test_k_extremes();
        write_k(5'd0);
        send_cand(20'd7, 4'd3, 4, 1, 20'd70, 4'd3, 1'b0);
        send_cand(20'd7, 4'd3, 4, 2, 20'd71, 4'd1, 1'b1);
        write_k(5'd16);
        send_query(17, 1, 2, 10);
        write_k(5'd31);
        send_cand(20'd8, 4'd1, 1, 1, 20'd80, 4'd1, 1'b0);
        send_cand(20'd8, 4'd1, 1, 0, 20'd81, 4'd9, 1'b1);
        write_k(5'd17);
        send_cand(20'd9, 4'd10, -5, 5, 20'd90, 4'd10, 1'b1);
    endtask

    task automatic test_random_traffic();
        int feed_pct [4] = '{0, 55, 0, 25};
        int sink_pct [4] = '{0, 0, 55, 25};
        int stop_at;
        int span;
        for (int ph = 0; ph < 4; ph++) begin
            write_k(($urandom_range(3) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(1, 8)));
            feed_idle_pct = feed_pct[ph];
            sink_stall_pct = sink_pct[ph];
            stop_at = items_sent + PHASE_ITEMS;
            while (items_sent < stop_at) begin
                span = $urandom_range(1) ? 0 : $urandom_range(1, 4);
                if ($urandom_range(9) == 0)
                    send_noise();
                else
                    send_query(($urandom_range(4) == 0) ? $urandom_range(7, 20)
                                                        : $urandom_range(1, 6),
                               $urandom_range(1, 3), span, 10);
                if ($urandom_range(9) == 0) drain_block();
            end
        end
        feed_idle_pct = 0;
        sink_stall_pct = 0;
    endtask

    initial begin
        k_setting = 5'd4;
        dist_sum = '0;
        foreach (top_used[i]) begin
            top_used[i] = 1'b0;
            top_dist[i] = '0;
            top_idx[i] = '0;
            top_lbl[i] = '0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_k();
        test_invalid_labels();
        test_mark_and_self();
        test_k_extremes();
        test_random_traffic();
        drain_block();

        $display("%0d transfers sent, %0d votes, %0d neighbour results checked",
                 items_sent, votes_predicted, results_checked);
        $display("%0d k writes incl. 0, 16, 17 and 31; ties, self skip, bad labels, idling",
                 k_writes);
        if (fail_count == 0 && pending_neighbours.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d failures, %0d results never seen", fail_count,
                     pending_neighbours.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
